// ----- src/draw_state_delta_encoder_unit_defines.svh -----
// Assertion macros for the draw state delta encoder.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef DRAW_STATE_DELTA_ENCODER_UNIT_DEFINES_SVH
`define DRAW_STATE_DELTA_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DSDE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DSDE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/dsde_pkg.sv -----
// Shared types and constants for the draw state delta encoder.
// No dependencies.
package dsde_pkg;

   // Default slot layout sizes
   localparam int BIND_GROUPS_DEF     = 4;
   localparam int DYN_BIND_GROUPS_DEF = 4;
   localparam int VTX_BUFFERS_DEF     = 8;
   localparam int QUEUE_DEPTH_DEF     = 4;

   // Slot index width in queue entries; covers up to 64 slots
   localparam int SLOT_IDX_W = 6;

   localparam logic [31:0] TRUE32  = 32'd1;
   localparam logic [31:0] FALSE32 = 32'd0;

   typedef enum logic [1:0] {
      OP_SET      = 2'd0,
      OP_DRAW_VTX = 2'd1,
      OP_DRAW_IDX = 2'd2
   } op_type;

   typedef enum logic {
      CMD_UPDATE = 1'b0,
      CMD_EMIT   = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [SLOT_IDX_W-1:0]  idx;
      logic [31:0]            value;
   } q_entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   // Expansion steps of a draw, offset from the slot after the index format slot
   typedef enum logic [2:0] {
      STEP_IDXOFF  = 3'd0,
      STEP_VTXOFF  = 3'd1,
      STEP_INSTOFF = 3'd2,
      STEP_PRIM    = 3'd3,
      STEP_INSTCNT = 3'd4,
      STEP_ISVTX   = 3'd5,
      STEP_EMIT    = 3'd6
   } step_type;

   typedef enum logic {
      FR_IDLE,
      FR_EXPAND
   } fr_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_CMP,
      BK_HDR,
      BK_SCAN_RD,
      BK_SCAN_WR
   } bk_state_type;

endpackage

// ----- src/dsde_if.sv -----
// Valid/ready channel interfaces for draw items and emitted stream words.
// No dependencies.
interface dsde_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [4:0]  slot;
   logic [31:0] value;
   logic [31:0] idx_offset;
   logic [31:0] vtx_offset;
   logic [31:0] inst_offset;
   logic [31:0] prim_count;
   logic [31:0] inst_count;

   modport source (output valid, op, slot, value, idx_offset, vtx_offset, inst_offset,
                   prim_count, inst_count, input ready);
   modport sink (input valid, op, slot, value, idx_offset, vtx_offset, inst_offset,
                 prim_count, inst_count, output ready);
endinterface

interface dsde_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] word;
   logic        is_header;
   logic [4:0]  slot_id;
   logic        last;

   modport source (output valid, word, is_header, slot_id, last, input ready);
   modport sink (input valid, word, is_header, slot_id, last, output ready);
endinterface

// ----- src/draw_state_delta_encoder_unit.sv -----
// Top level of the draw state delta encoder: front end, command queue, back end.
// Depends on dsde_pkg, dsde_if.sv, dsde_front, dsde_queue, dsde_back and the defines header.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+---------------------------------------------
//   req_if   | in  | valid/ready        | op, slot, value, idx/vtx/inst offset, counts
//   rsp_if   | out | valid/ready        | word, is_header, slot_id, last
//
// Set: one handshake to transfer, then a back-end store read, then compare and write.
// Draw: front feeds 5 or 6 slot updates plus an emit command, one per cycle unless the queue
//   is full; back end: read+compare per update, header, read+send per dirty slot (read port).
// Reset is synchronous; slot store valid bits read as zero at once, no clearing pass.
// A stalled rsp_if holds the back end; the queue lets the front keep taking items.
`include "draw_state_delta_encoder_unit_defines.svh"

module draw_state_delta_encoder_unit
   import dsde_pkg::*;
#(
   parameter int BIND_GROUPS     = BIND_GROUPS_DEF,
   parameter int DYN_BIND_GROUPS = DYN_BIND_GROUPS_DEF,
   parameter int VTX_BUFFERS     = VTX_BUFFERS_DEF,
   parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   dsde_req_if.sink    req_if,
   dsde_rsp_if.source  rsp_if
);

   // pipeline, bind groups, dyn bind groups, index buffer, vertex buffers,
   // index format, six draw slots, dynamic offsets
   localparam int NumSlots = 9 + BIND_GROUPS + 2 * DYN_BIND_GROUPS + VTX_BUFFERS;
   localparam int QAddrW   = $clog2(QUEUE_DEPTH);

   logic          push, pop;
   q_entry_type   push_entry, head;
   q_status_type  q_status;
   logic [QAddrW:0] q_level;

   dsde_front #(
      .BIND_GROUPS     (BIND_GROUPS),
      .DYN_BIND_GROUPS (DYN_BIND_GROUPS),
      .VTX_BUFFERS     (VTX_BUFFERS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   dsde_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status),
      .level      (q_level)
   );

   dsde_back #(
      .NUM_SLOTS (NumSlots)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp_if   (rsp_if)
   );

   // a header marked last means nothing was dirty
   `DSDE_ASSERT_NOW(a_clean_hdr, clock, reset, rsp_if.valid && rsp_if.is_header && rsp_if.last, rsp_if.word == 32'd0, "last header with nonzero mask")
   // value words name an existing slot
   `DSDE_ASSERT_NOW(a_sid_range, clock, reset, rsp_if.valid && !rsp_if.is_header, 32'(rsp_if.slot_id) < 32'(NumSlots), "slot id out of range")
   // queue never overfills
   `DSDE_ASSERT_NOW(a_q_level, clock, reset, 1'b1, 32'(q_level) <= 32'(QUEUE_DEPTH), "queue level above depth")
   // an accepted draw blocks the front on the next cycle while it expands
   `DSDE_ASSERT_NEXT(a_draw_busy, clock, reset, req_if.valid && req_if.ready && (req_if.op == OP_DRAW_VTX || req_if.op == OP_DRAW_IDX), !req_if.ready, "front ready during draw expansion")

endmodule

// ----- src/dsde_front.sv -----
// Front end: accepts items, drops ignored ones, expands draws into slot updates.
// Depends on dsde_pkg and dsde_req_if.
module dsde_front
   import dsde_pkg::*;
#(
   parameter int BIND_GROUPS     = BIND_GROUPS_DEF,
   parameter int DYN_BIND_GROUPS = DYN_BIND_GROUPS_DEF,
   parameter int VTX_BUFFERS     = VTX_BUFFERS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   dsde_req_if.sink      req_if,
   input  q_status_type  q_status,
   output logic          push,
   output q_entry_type   push_entry
);

   localparam int IdxFmt   = 2 + BIND_GROUPS + DYN_BIND_GROUPS + VTX_BUFFERS;
   localparam int NumSlots = IdxFmt + 7 + DYN_BIND_GROUPS;

   fr_state_type state_ff, state_in;
   step_type     step_ff, step_in;
   logic         is_vtx_ff;
   logic [31:0]  idx_off_ff, vtx_off_ff, inst_off_ff, prim_ff, inst_cnt_ff;
   logic         accept, is_draw, set_ok;

   assign req_if.ready = (state_ff == FR_IDLE) && !q_status.full;
   assign accept       = req_if.valid && req_if.ready;
   assign is_draw      = (req_if.op == OP_DRAW_VTX) || (req_if.op == OP_DRAW_IDX);
   assign set_ok       = (req_if.op == OP_SET) && (32'(req_if.slot) < 32'(NumSlots));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FR_IDLE: begin
            if (accept && is_draw) state_in = FR_EXPAND;
         end
         FR_EXPAND: begin
            if (!q_status.full && step_ff == STEP_EMIT) state_in = FR_IDLE;
         end
         default: state_in = FR_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      push       = 1'b0;
      push_entry = '{cmd: CMD_UPDATE, idx: '0, value: '0};
      step_in    = step_ff;
      case (state_ff)
         FR_IDLE: begin
            push             = accept && set_ok;
            push_entry.idx   = SLOT_IDX_W'(req_if.slot);
            push_entry.value = req_if.value;
            if (req_if.op == OP_DRAW_IDX) step_in = STEP_IDXOFF;
            else                          step_in = STEP_VTXOFF;
         end
         FR_EXPAND: begin
            push           = !q_status.full;
            push_entry.cmd = (step_ff == STEP_EMIT) ? CMD_EMIT : CMD_UPDATE;
            push_entry.idx = SLOT_IDX_W'(IdxFmt + 1) + SLOT_IDX_W'(step_ff);
            case (step_ff)
               STEP_IDXOFF:  push_entry.value = idx_off_ff;
               STEP_VTXOFF:  push_entry.value = vtx_off_ff;
               STEP_INSTOFF: push_entry.value = inst_off_ff;
               STEP_PRIM:    push_entry.value = prim_ff;
               STEP_INSTCNT: push_entry.value = inst_cnt_ff;
               STEP_ISVTX:   push_entry.value = is_vtx_ff ? TRUE32 : FALSE32;
               default:      push_entry.value = '0;
            endcase
            if (!q_status.full) step_in = step_type'(step_ff + 3'd1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         step_ff  <= STEP_IDXOFF;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // draw payload, captured on transfer
   always_ff @(posedge clock) begin
      if (accept && is_draw) begin
         is_vtx_ff   <= (req_if.op == OP_DRAW_VTX);
         idx_off_ff  <= req_if.idx_offset;
         vtx_off_ff  <= req_if.vtx_offset;
         inst_off_ff <= req_if.inst_offset;
         prim_ff     <= req_if.prim_count;
         inst_cnt_ff <= req_if.inst_count;
      end
   end

endmodule

// ----- src/dsde_queue.sv -----
// Command queue between front and back end.
// Depends on dsde_pkg.
module dsde_queue
   import dsde_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  q_entry_type                    push_entry,
   input  logic                           pop,
   output q_entry_type                    head,
   output q_status_type                   status,
   output logic [$clog2(QUEUE_DEPTH):0]   level
);

   localparam int AddrW = $clog2(QUEUE_DEPTH);

   q_entry_type            entries_ff [QUEUE_DEPTH];
   logic [AddrW-1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AddrW:0]         count_ff, count_in;
   logic                   do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (AddrW + 1)'(QUEUE_DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = entries_ff[rd_ptr_ff];
   assign level        = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AddrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AddrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

// ----- src/dsde_back.sv -----
// Back end: slot store with compare-and-mark, dirty mask, header and slot emission.
// Depends on dsde_pkg and dsde_rsp_if.
module dsde_back
   import dsde_pkg::*;
#(
   parameter int NUM_SLOTS = 9 + BIND_GROUPS_DEF + 2 * DYN_BIND_GROUPS_DEF + VTX_BUFFERS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  q_entry_type   head,
   input  q_status_type  q_status,
   output logic          pop,
   dsde_rsp_if.source    rsp_if
);

   localparam int IdxW = $clog2(NUM_SLOTS);

   bk_state_type state_ff, state_in;

   // slot store: one write port, one registered read port; valid bits give reset zero
   logic [31:0]          slot_mem_ff [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] slot_ok_ff;
   logic [31:0]          rd_raw_ff;
   logic                 rd_ok_ff;
   logic [31:0]          rd_data;
   logic                 rd_en, wr_en;
   logic [IdxW-1:0]      rd_addr;

   logic [IdxW-1:0]      upd_idx_ff;
   logic [31:0]          upd_val_ff;
   logic [NUM_SLOTS-1:0] dirty_ff, dirty_in;
   logic [NUM_SLOTS-1:0] work_ff, work_in;
   logic [IdxW-1:0]      scan_idx_ff, scan_idx_in;
   logic [NUM_SLOTS-1:0] work_neg, work_lsb;
   logic [IdxW-1:0]      lsb_idx;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_word_ff;
   logic                 rsp_hdr_ff, rsp_last_ff;
   logic [4:0]           rsp_sid_ff;
   logic                 load, load_hdr, load_last, out_free;
   logic [31:0]          load_word;
   logic [4:0]           load_sid;

   assign rd_data  = rd_ok_ff ? rd_raw_ff : 32'd0;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // lowest dirty slot still to send
   assign work_neg = ~work_ff + 1'b1;
   assign work_lsb = work_ff & work_neg;
   always_comb begin
      lsb_idx = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (work_lsb[i]) lsb_idx = lsb_idx | IdxW'(i);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               state_in = (head.cmd == CMD_EMIT) ? BK_HDR : BK_CMP;
            end
         end
         BK_CMP: state_in = BK_IDLE;
         BK_HDR: begin
            if (out_free) state_in = (dirty_ff == '0) ? BK_IDLE : BK_SCAN_RD;
         end
         BK_SCAN_RD: state_in = BK_SCAN_WR;
         BK_SCAN_WR: begin
            if (out_free) state_in = (work_ff == '0) ? BK_IDLE : BK_SCAN_RD;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop         = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = head.idx[IdxW-1:0];
      wr_en       = 1'b0;
      dirty_in    = dirty_ff;
      work_in     = work_ff;
      scan_idx_in = scan_idx_ff;
      load        = 1'b0;
      load_word   = rd_data;
      load_hdr    = 1'b0;
      load_sid    = 5'(scan_idx_ff);
      load_last   = (work_ff == '0);
      case (state_ff)
         BK_IDLE: begin
            pop   = !q_status.empty;
            rd_en = !q_status.empty && (head.cmd == CMD_UPDATE);
         end
         BK_CMP: begin
            if (rd_data != upd_val_ff) begin
               wr_en                = 1'b1;
               dirty_in[upd_idx_ff] = 1'b1;
            end
         end
         BK_HDR: begin
            load_word = 32'(dirty_ff);
            load_hdr  = 1'b1;
            load_sid  = 5'd0;
            load_last = (dirty_ff == '0);
            if (out_free) begin
               load     = 1'b1;
               work_in  = dirty_ff;
               dirty_in = '0;
            end
         end
         BK_SCAN_RD: begin
            rd_en       = 1'b1;
            rd_addr     = lsb_idx;
            work_in     = work_ff & ~work_lsb;
            scan_idx_in = lsb_idx;
         end
         BK_SCAN_WR: begin
            load = out_free;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load)              rsp_valid_in = 1'b1;
      else if (rsp_if.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         dirty_ff     <= '0;
         work_ff      <= '0;
         slot_ok_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dirty_ff     <= dirty_in;
         work_ff      <= work_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) slot_ok_ff[upd_idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) slot_mem_ff[upd_idx_ff] <= upd_val_ff;
      if (rd_en) begin
         rd_raw_ff <= slot_mem_ff[rd_addr];
         rd_ok_ff  <= slot_ok_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      if (pop) begin
         upd_idx_ff <= head.idx[IdxW-1:0];
         upd_val_ff <= head.value;
      end
      if (load) begin
         rsp_word_ff <= load_word;
         rsp_hdr_ff  <= load_hdr;
         rsp_sid_ff  <= load_sid;
         rsp_last_ff <= load_last;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.word      = rsp_word_ff;
   assign rsp_if.is_header = rsp_hdr_ff;
   assign rsp_if.slot_id   = rsp_sid_ff;
   assign rsp_if.last      = rsp_last_ff;

endmodule
